/* hw/rtl/tsched_pkg.sv */
// Shared types and constants for the thread scheduler.
`default_nettype none
package tsched_pkg;
  localparam int MaxContexts   = 16;
  localparam int NumSemaphores = 8;
  localparam int CountBits     = 16;
  localparam int IdW  = $clog2(MaxContexts);
  localparam int SemW = (NumSemaphores > 1) ? $clog2(NumSemaphores) : 1;
  localparam int CntW = $clog2(MaxContexts + 1);

  typedef logic [IdW-1:0] ctx_id_t;
  typedef logic [IdW:0] wptr_t;  // MSB set means no waiter
  typedef logic signed [CountBits-1:0] count_t;

  typedef enum logic [2:0] {
    FN_CREATE = 3'd0, FN_YIELD = 3'd1, FN_FINISH = 3'd2,
    FN_SINIT = 3'd3, FN_SUP = 3'd4, FN_SDOWN = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    CS_FREE = 2'd0, CS_INIT = 2'd1, CS_EXEC = 2'd2, CS_BLK = 2'd3
  } cstate_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_NORUN = 2'd2, ST_NOWAIT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_WSTART, S_WSTEP, S_DONE
  } fsm_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch request
    logic exec;       // perform the non-yield part of the request
    logic wstart;     // start ring walk
    logic wstep;      // examine one ring entry
    logic out_load;   // move result to output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_walk;  // request needs a ring walk
    logic walk_done;  // walk found a context or ran out
  } sts_t;
endpackage
`default_nettype wire

/* hw/rtl/thread_scheduler_with_semaphores_top.sv */
// Top level of the round-robin thread scheduler with counting semaphores.
// Usage:
//   Input channel: func, sem_id, init_count with in_valid / in_stall.
//   Output channel: current_id, current_valid, new_id, started, status
//   with out_valid / out_stall. Exactly one result per request.
//   One request is processed at a time. Non-yield requests go from
//   acceptance through the body step to a loaded result. Requests that
//   yield (yield, finish, a blocking down) walk the context ring one
//   link read per cycle, and the link walk sets the rate.
//   The result register holds the result while out_stall is high; the
//   next request is accepted once the result is loaded.
//   Reset (synchronous, rst high) empties the ring, zeroes all semaphore
//   counts and empties their waiter stacks; no result is pending.
`default_nettype none
module thread_scheduler_with_semaphores_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        func,
  input  wire logic [2:0]        sem_id,
  input  wire logic signed [15:0] init_count,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [3:0]             current_id,
  output logic                   current_valid,
  output logic [3:0]             new_id,
  output logic                   started,
  output logic [1:0]             status
);
  import tsched_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tsched_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .cmd(cmd), .sts(sts)
  );

  tsched_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .func(func),
    .sem_id(sem_id), .init_count(init_count), .current_id(current_id),
    .current_valid(current_valid), .new_id(new_id), .started(started),
    .status(status)
  );

  // Commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.exec, cmd.wstart, cmd.wstep, cmd.out_load}))
    else $error("overlapping datapath commands");

  // A request acceptance is followed by the body step
  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> cmd.exec)
    else $error("request not executed");

  // No current id reported when nothing runs
  a_idle_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !current_valid) |-> (current_id == 4'd0))
    else $error("current id set without running context");
endmodule
`default_nettype wire

/* hw/rtl/tsched_ctrl.sv */
// Controller state machine sequencing one request at a time.
`default_nettype none
module tsched_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output tsched_pkg::cmd_t        cmd,
  input  wire tsched_pkg::sts_t   sts
);
  import tsched_pkg::*;

  fsm_t state, state_next;
  logic ovld, ovld_next;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_EXEC;
      S_EXEC:   state_next = sts.need_walk ? S_WSTART : S_DONE;
      S_WSTART: state_next = S_WSTEP;
      S_WSTEP:  if (sts.walk_done) state_next = S_DONE;
      S_DONE:   if (!ovld || !out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = 1'b1;
      end
      S_EXEC:   cmd.exec = 1'b1;
      S_WSTART: cmd.wstart = 1'b1;
      S_WSTEP:  cmd.wstep = 1'b1;
      S_DONE:   cmd.out_load = !ovld || !out_stall;
      default:  cmd = '0;
    endcase
  end

  // Output register valid
  always_comb begin
    ovld_next = ovld;
    if (ovld && !out_stall) ovld_next = 1'b0;
    if (cmd.out_load) ovld_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ovld  <= 1'b0;
    end else begin
      state <= state_next;
      ovld  <= ovld_next;
    end
  end

  assign out_valid = ovld;
endmodule
`default_nettype wire

/* hw/rtl/tsched_dp.sv */
// Datapath: context ring, semaphores, waiter stacks and result register.
`default_nettype none
module tsched_dp (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire tsched_pkg::cmd_t       cmd,
  output tsched_pkg::sts_t            sts,
  input  wire logic [2:0]             func,
  input  wire logic [2:0]             sem_id,
  input  wire logic signed [15:0]     init_count,
  output logic [3:0]                  current_id,
  output logic                        current_valid,
  output logic [3:0]                  new_id,
  output logic                        started,
  output logic [1:0]                  status
);
  import tsched_pkg::*;

  localparam count_t CMax = count_t'({1'b0, {(CountBits-1){1'b1}}});
  localparam count_t CMin = count_t'({1'b1, {(CountBits-1){1'b0}}});
  localparam wptr_t NoCtx = wptr_t'(MaxContexts);

  ctx_id_t next_link [MaxContexts];
  wptr_t   waiter_link [MaxContexts];
  cstate_t ctx_phase [MaxContexts];
  count_t  sem_counter [NumSemaphores];
  wptr_t   waiter_head [NumSemaphores];
  logic [CntW-1:0] ctx_count;
  ctx_id_t running_id;
  logic    running_valid;

  // Latched request
  func_t   r_func;
  logic [2:0] r_sid;
  logic signed [15:0] r_ic;
  logic    need_walk;
  ctx_id_t cur;
  logic [CntW-1:0] steps;
  logic    walk_done;
  status_t r_status;
  logic    r_started;
  ctx_id_t r_new;

  logic    sem_ok;
  logic [SemW-1:0] sidx;
  count_t  cnt, cnt_up, cnt_dn, ic_clamp;
  cstate_t cs_cur;
  logic    runnable;

  assign sem_ok = {29'd0, r_sid} < 32'(NumSemaphores);
  assign sidx   = SemW'(r_sid);
  assign cnt    = sem_counter[sidx];
  assign cnt_up = (cnt < CMax) ? cnt + count_t'(1) : cnt;
  assign cnt_dn = (cnt > CMin) ? cnt - count_t'(1) : cnt;
  assign cs_cur = ctx_phase[cur];
  assign runnable = (cs_cur == CS_INIT) || (cs_cur == CS_EXEC);

  // Walk decision, taken from state before the request body is applied
  assign need_walk = (r_func == FN_YIELD) ||
                     ((r_func == FN_FINISH) && running_valid) ||
                     ((r_func == FN_SDOWN) && sem_ok && running_valid && (cnt_dn < 0));

  // Clamp 16-bit input into the count range
  always_comb begin
    if (CountBits >= 16) ic_clamp = count_t'(r_ic);
    else if (32'(signed'(r_ic)) > 32'(signed'(CMax))) ic_clamp = CMax;
    else if (32'(signed'(r_ic)) < 32'(signed'(CMin))) ic_clamp = CMin;
    else ic_clamp = count_t'(r_ic);
  end

  assign sts.need_walk = need_walk;
  assign sts.walk_done = walk_done;

  // Control and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxContexts; i++) ctx_phase[i] <= CS_FREE;
      for (int i = 0; i < NumSemaphores; i++) begin
        sem_counter[i] <= '0;
        waiter_head[i] <= NoCtx;
      end
      ctx_count <= '0;
      running_id <= '0;
      running_valid <= 1'b0;
      walk_done <= 1'b0;
    end else begin
      if (cmd.capture) begin
        r_func <= func_t'(func);
        r_sid <= sem_id;
        r_ic <= init_count;
        r_status <= ST_OK;
        r_started <= 1'b0;
        r_new <= '0;
      end
      // Request body
      if (cmd.exec) begin
        unique case (r_func)
          FN_CREATE: begin
            if (ctx_count >= CntW'(MaxContexts)) r_status <= ST_FULL;
            else begin
              ctx_phase[IdW'(ctx_count)] <= CS_INIT;
              if (ctx_count == '0) next_link[0] <= '0;
              else begin
                next_link[IdW'(ctx_count)] <= next_link[0];
                next_link[0] <= IdW'(ctx_count);
              end
              ctx_count <= ctx_count + CntW'(1);
              r_new <= IdW'(ctx_count);
            end
          end
          FN_YIELD: ;
          FN_FINISH: if (running_valid) begin
            ctx_phase[running_id] <= CS_FREE;
          end
          FN_SINIT: if (sem_ok) begin
            sem_counter[sidx] <= ic_clamp;
            waiter_head[sidx] <= NoCtx;
          end
          FN_SUP: if (sem_ok) begin
            sem_counter[sidx] <= cnt_up;
            if (cnt_up <= 0) begin
              if (waiter_head[sidx][IdW]) r_status <= ST_NOWAIT;
              else begin
                ctx_phase[IdW'(waiter_head[sidx])] <= CS_EXEC;
                waiter_head[sidx] <= waiter_link[IdW'(waiter_head[sidx])];
              end
            end
          end
          FN_SDOWN: if (sem_ok) begin
            if (!running_valid) r_status <= ST_NORUN;
            else begin
              sem_counter[sidx] <= cnt_dn;
              if (cnt_dn < 0) begin
                ctx_phase[running_id] <= CS_BLK;
                waiter_link[running_id] <= waiter_head[sidx];
                waiter_head[sidx] <= {1'b0, running_id};
              end
            end
          end
          default: ;
        endcase
      end
      // Ring walk: one link read per cycle
      if (cmd.wstart) begin
        walk_done <= (ctx_count == '0);
        steps <= '0;
        cur <= running_valid ? next_link[running_id] : '0;
        if (ctx_count == '0) begin
          running_valid <= 1'b0;
          running_id <= '0;
          r_status <= ST_NORUN;
        end
      end
      if (cmd.wstep && !walk_done) begin
        if (runnable) begin
          running_id <= cur;
          running_valid <= 1'b1;
          walk_done <= 1'b1;
          if (cs_cur == CS_INIT) begin
            ctx_phase[cur] <= CS_EXEC;
            r_started <= 1'b1;
          end
        end else if (steps == CntW'(MaxContexts - 1)) begin
          running_valid <= 1'b0;
          running_id <= '0;
          walk_done <= 1'b1;
          r_status <= ST_NORUN;
        end else begin
          cur <= next_link[cur];
          steps <= steps + CntW'(1);
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      current_id <= running_valid ? 4'(running_id) : 4'd0;
      current_valid <= running_valid;
      new_id <= 4'(r_new);
      started <= r_started;
      status <= r_status;
    end
  end
endmodule
`default_nettype wire
